@@ sv/bapf_pkg.sv @@
// Package for the Bezier arrow point finder: widths, stage numbers, payload
// types and the per-stage arithmetic steps (square root, division, lerp).
// No dependencies.
package bapf_pkg;

	localparam int COORD_W    = 24;
	localparam int T_FRAC     = 16;
	localparam int RES_W      = 24;
	localparam int ARROW_W    = 8;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 1;

	localparam int V_W    = COORD_W + 5;
	localparam int MAG_W  = COORD_W + 4;
	localparam int N_W    = 2 * MAG_W + 1;
	localparam int ROOT_W = MAG_W + 1;
	localparam int TR_W   = 2 * ROOT_W;
	localparam int SUM_W  = ROOT_W + 3;
	localparam int AR_W   = ARROW_W + RES_W;
	localparam int NUM_W  = AR_W + 5 + T_FRAC - 8;
	localparam int Q_W    = T_FRAC + 1;
	localparam int TS_W   = Q_W + 1;
	localparam int DREM_W = (NUM_W > SUM_W + Q_W) ? NUM_W : SUM_W + Q_W;
	localparam int LW     = COORD_W + Q_W + 2;

	localparam logic [Q_W-1:0] ONE_T  = Q_W'(1) << T_FRAC;
	localparam logic [Q_W-1:0] HALF_T = Q_W'(1) << (T_FRAC - 1);

	localparam int ST_V    = 1;
	localparam int ST_SQ   = 2;
	localparam int ST_RT0  = 3;
	localparam int ST_RTN  = ST_RT0 + ROOT_W - 1;
	localparam int ST_SUM  = ST_RTN + 1;
	localparam int ST_DV0  = ST_SUM + 1;
	localparam int ST_DVN  = ST_DV0 + Q_W - 1;
	localparam int ST_T    = ST_DVN + 1;
	localparam int ST_L1   = ST_T + 1;
	localparam int ST_L2   = ST_L1 + 1;
	localparam int ST_L3   = ST_L2 + 1;
	localparam int ST_LAST = ST_L3;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_RES   = 1'b0,
		REG_ARROW_OFFSET = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t ctrl1_x;
		coord_t ctrl1_y;
		coord_t ctrl2_x;
		coord_t ctrl2_y;
		coord_t end_x;
		coord_t end_y;
	} in_item_t;

	typedef struct packed {
		coord_t mid_x;
		coord_t mid_y;
		coord_t toward_start_x;
		coord_t toward_start_y;
		coord_t toward_end_x;
		coord_t toward_end_y;
		logic   param_clamped;
		logic   degenerate;
	} out_item_t;

	typedef struct packed {
		logic [N_W-1:0]    rem;
		logic [ROOT_W-1:0] root;
	} rt_pair_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [Q_W-1:0]    quo;
		logic [SUM_W-1:0]  sum;
		logic              ovf;
		logic              deg;
	} dv_pair_t;

	// one result bit of the square root, remainder kept as n - root^2
	function automatic rt_pair_t rt_step(rt_pair_t x, int b);
		logic [TR_W-1:0] trial;
		rt_pair_t y;
		y = x;
		trial = (TR_W'(x.root) << (b + 1)) | (TR_W'(1) << (2 * b));
		if (trial <= TR_W'(x.rem)) begin
			y.rem  = x.rem - trial[N_W-1:0];
			y.root = x.root | (ROOT_W'(1) << b);
		end
		return y;
	endfunction

	// one quotient bit of restoring division
	function automatic dv_pair_t dv_step(dv_pair_t x, int b);
		logic [DREM_W-1:0] sh;
		dv_pair_t y;
		y = x;
		sh = DREM_W'(x.sum) << b;
		if (x.rem >= sh) begin
			y.rem = x.rem - sh;
			y.quo = x.quo | (Q_W'(1) << b);
		end
		return y;
	endfunction

	// a + round((b - a) * t), half rounds up
	function automatic coord_t lerp(coord_t a, coord_t b, logic [Q_W-1:0] t);
		logic signed [COORD_W:0] diff;
		logic signed [LW-1:0] w;
		diff = (COORD_W + 1)'(b) - (COORD_W + 1)'(a);
		w = LW'(diff) * LW'($signed({1'b0, t})) + LW'(HALF_T);
		return coord_t'(a + $signed(w[T_FRAC+COORD_W-1:T_FRAC]));
	endfunction

endpackage

@@ sv/bezier_arrow_point_finder_unit.sv @@
// Top level of the Bezier arrow point finder: length estimate, offset
// division and three curve evaluations in one stall-able pipeline.
// Depends on bapf_pkg.

// One cubic curve per transfer goes in, one result with three curve points
// comes out; a new curve is taken every cycle unless a full, stalled output
// blocks the pipeline. In order, one stage forms the scaled derivatives,
// one squares them, 29 stages extract the four square roots a bit each,
// one sums the Simpson weights, 17 stages divide arrow * resolution by the
// length a quotient bit each, one picks the parameters, three run de
// Casteljau, and an output register holds the result. When the output
// stalls, the pipeline keeps moving until a valid result reaches its last
// stage, so bubbles drain and input is still taken.
// Write configuration only with no curve in flight; the new offset product
// is registered in num_q behind the configuration registers.
module bezier_arrow_point_finder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  bapf_pkg::cfg_reg_t                  cfg_index,
	input  logic [bapf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  bapf_pkg::in_item_t                  item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output bapf_pkg::out_item_t                 result
);
	import bapf_pkg::*;

	logic [RES_W-1:0]   res_q;
	logic [ARROW_W-1:0] arrow_q;
	logic [AR_W-1:0]    ar_prod;
	logic [NUM_W-1:0]   num_q;

	logic en;
	logic vld_s [1:ST_LAST];
	in_item_t pt_s [1:ST_T];

	logic signed [V_W-1:0] vx_d [4];
	logic signed [V_W-1:0] vy_d [4];
	logic signed [V_W-1:0] vx_s1 [4];
	logic signed [V_W-1:0] vy_s1 [4];
	logic [N_W-1:0] n_d [4];
	logic [N_W-1:0] n_s2 [4];

	rt_pair_t rt_d [ST_RT0:ST_RTN][4];
	rt_pair_t rt_s [ST_RT0:ST_RTN][4];
	logic [SUM_W-1:0] sum_d;
	logic [SUM_W-1:0] sum_s4;

	dv_pair_t dv_d [ST_DV0:ST_DVN];
	dv_pair_t dv_s [ST_DV0:ST_DVN];

	logic [Q_W-1:0] t_d [3];
	logic           clamp_d;
	logic [Q_W-1:0] t_s [ST_T:ST_L2][3];
	logic           clamp_s [ST_T:ST_L3];
	logic           deg_s [ST_T:ST_L3];

	coord_t lv1_d [3][2][3];
	coord_t lv1_s [3][2][3];
	coord_t lv2_d [3][2][2];
	coord_t lv2_s [3][2][2];
	coord_t lv3_d [3][2];
	coord_t lv3_s [3][2];

	logic      res_v_q;
	out_item_t res_q_item;

	// Advance the whole pipeline unless a valid result in the last stage
	// cannot move into a full, stalled output register.
	assign en         = !vld_s[ST_LAST] || !res_v_q || result_ready;
	assign item_ready = en;

	// offset product arrow * resolution; num_q scales it by 24 and aligns it to the t fraction
	assign ar_prod = arrow_q * res_q;

	// stage 1: three times the derivative at t = 0, 1/3, 2/3, 1
	always_comb begin
		logic signed [V_W-1:0] dx0, dx1, dx2, dy0, dy1, dy2;
		dx0 = V_W'(item.ctrl1_x) - V_W'(item.start_x);
		dx1 = V_W'(item.ctrl2_x) - V_W'(item.ctrl1_x);
		dx2 = V_W'(item.end_x)   - V_W'(item.ctrl2_x);
		dy0 = V_W'(item.ctrl1_y) - V_W'(item.start_y);
		dy1 = V_W'(item.ctrl2_y) - V_W'(item.ctrl1_y);
		dy2 = V_W'(item.end_y)   - V_W'(item.ctrl2_y);
		vx_d[0] = (dx0 <<< 3) + dx0;
		vx_d[1] = (dx0 <<< 2) + (dx1 <<< 2) + dx2;
		vx_d[2] = dx0 + (dx1 <<< 2) + (dx2 <<< 2);
		vx_d[3] = (dx2 <<< 3) + dx2;
		vy_d[0] = (dy0 <<< 3) + dy0;
		vy_d[1] = (dy0 <<< 2) + (dy1 <<< 2) + dy2;
		vy_d[2] = dy0 + (dy1 <<< 2) + (dy2 <<< 2);
		vy_d[3] = (dy2 <<< 3) + dy2;
	end

	// stage 2: squared speed per sample point
	always_comb begin
		logic [V_W-1:0]     ux, uy;
		logic [MAG_W-1:0]   ax, ay;
		logic [2*MAG_W-1:0] sx, sy;
		for (int l = 0; l < 4; l++) begin
			ux = vx_s1[l][V_W-1] ? V_W'(-vx_s1[l]) : V_W'(vx_s1[l]);
			uy = vy_s1[l][V_W-1] ? V_W'(-vy_s1[l]) : V_W'(vy_s1[l]);
			ax = ux[MAG_W-1:0];
			ay = uy[MAG_W-1:0];
			sx = ax * ax;
			sy = ay * ay;
			n_d[l] = N_W'(sx) + N_W'(sy);
		end
	end

	// square root stages, one result bit per stage, most significant first
	always_comb begin
		rt_pair_t init;
		for (int l = 0; l < 4; l++) begin
			init.rem  = n_s2[l];
			init.root = '0;
			rt_d[ST_RT0][l] = rt_step(init, ROOT_W - 1);
			for (int j = ST_RT0 + 1; j <= ST_RTN; j++)
				rt_d[j][l] = rt_step(rt_s[j-1][l], ST_RTN - j);
		end
	end

	// Simpson 3/8 weights 1, 3, 3, 1
	always_comb begin
		logic [SUM_W-1:0] m0, m1, m2, m3;
		m0 = SUM_W'(rt_s[ST_RTN][0].root);
		m1 = SUM_W'(rt_s[ST_RTN][1].root);
		m2 = SUM_W'(rt_s[ST_RTN][2].root);
		m3 = SUM_W'(rt_s[ST_RTN][3].root);
		sum_d = m0 + m1 + (m1 << 1) + m2 + (m2 << 1) + m3;
	end

	// divider stages; the first also flags a quotient too large to matter
	always_comb begin
		dv_pair_t init;
		init.rem = DREM_W'(num_q);
		init.quo = '0;
		init.sum = sum_s4;
		init.ovf = DREM_W'(num_q) >= (DREM_W'(sum_s4) << Q_W);
		init.deg = (sum_s4 == '0);
		dv_d[ST_DV0] = dv_step(init, Q_W - 1);
		for (int j = ST_DV0 + 1; j <= ST_DVN; j++)
			dv_d[j] = dv_step(dv_s[j-1], ST_DVN - j);
	end

	// parameter pick: zero length evaluates every point at t = 0
	always_comb begin
		logic [Q_W-1:0] q;
		q = dv_s[ST_DVN].quo;
		clamp_d = 1'b0;
		if (dv_s[ST_DVN].deg) begin
			t_d[0] = '0;
			t_d[1] = '0;
			t_d[2] = '0;
		end else if (dv_s[ST_DVN].ovf || q > HALF_T) begin
			t_d[0] = HALF_T;
			t_d[1] = '0;
			t_d[2] = ONE_T;
			clamp_d = 1'b1;
		end else begin
			t_d[0] = HALF_T;
			t_d[1] = HALF_T - q;
			t_d[2] = HALF_T + q;
		end
	end

	// de Casteljau, one level per stage
	always_comb begin
		coord_t p [2][4];
		p[0][0] = pt_s[ST_T].start_x;
		p[0][1] = pt_s[ST_T].ctrl1_x;
		p[0][2] = pt_s[ST_T].ctrl2_x;
		p[0][3] = pt_s[ST_T].end_x;
		p[1][0] = pt_s[ST_T].start_y;
		p[1][1] = pt_s[ST_T].ctrl1_y;
		p[1][2] = pt_s[ST_T].ctrl2_y;
		p[1][3] = pt_s[ST_T].end_y;
		for (int tt = 0; tt < 3; tt++)
			for (int a = 0; a < 2; a++)
				for (int k = 0; k < 3; k++)
					lv1_d[tt][a][k] = lerp(p[a][k], p[a][k+1], t_s[ST_T][tt]);
	end

	always_comb begin
		for (int tt = 0; tt < 3; tt++)
			for (int a = 0; a < 2; a++) begin
				for (int k = 0; k < 2; k++)
					lv2_d[tt][a][k] = lerp(lv1_s[tt][a][k], lv1_s[tt][a][k+1],
						t_s[ST_L1][tt]);
				lv3_d[tt][a] = lerp(lv2_s[tt][a][0], lv2_s[tt][a][1], t_s[ST_L2][tt]);
			end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q   <= RES_W'(65536);
			arrow_q <= ARROW_W'(4);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SAMPLE_RES:   res_q   <= cfg_data[RES_W-1:0];
				REG_ARROW_OFFSET: arrow_q <= cfg_data[ARROW_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits travel with the data; the output register holds a result
	// until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= ST_LAST; j++)
				vld_s[j] <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (en) begin
				vld_s[1] <= item_valid;
				for (int j = 2; j <= ST_LAST; j++)
					vld_s[j] <= vld_s[j-1];
			end
			if (!res_v_q || result_ready)
				res_v_q <= vld_s[ST_LAST];
		end
	end

	always_ff @(posedge clk) begin
		num_q <= ((NUM_W'(ar_prod) << 4) + (NUM_W'(ar_prod) << 3)) << (T_FRAC - 8);
		if (en) begin
			pt_s[1] <= item;
			for (int j = 2; j <= ST_T; j++)
				pt_s[j] <= pt_s[j-1];
			vx_s1 <= vx_d;
			vy_s1 <= vy_d;
			n_s2  <= n_d;
			rt_s  <= rt_d;
			sum_s4 <= sum_d;
			dv_s  <= dv_d;
			t_s[ST_T]     <= t_d;
			clamp_s[ST_T] <= clamp_d;
			deg_s[ST_T]   <= dv_s[ST_DVN].deg;
			for (int j = ST_L1; j <= ST_L2; j++)
				t_s[j] <= t_s[j-1];
			for (int j = ST_L1; j <= ST_L3; j++) begin
				clamp_s[j] <= clamp_s[j-1];
				deg_s[j]   <= deg_s[j-1];
			end
			lv1_s <= lv1_d;
			lv2_s <= lv2_d;
			lv3_s <= lv3_d;
		end
		if (!res_v_q || result_ready) begin
			res_q_item.mid_x          <= lv3_s[0][0];
			res_q_item.mid_y          <= lv3_s[0][1];
			res_q_item.toward_start_x <= lv3_s[1][0];
			res_q_item.toward_start_y <= lv3_s[1][1];
			res_q_item.toward_end_x   <= lv3_s[2][0];
			res_q_item.toward_end_y   <= lv3_s[2][1];
			res_q_item.param_clamped  <= clamp_s[ST_L3];
			res_q_item.degenerate     <= deg_s[ST_L3];
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q_item;

`ifndef SYNTH
	a_deg_points: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
			!result.param_clamped && result.mid_x == result.toward_start_x &&
			result.mid_x == result.toward_end_x && result.mid_y == result.toward_end_y)
		else $error("degenerate result with differing points or clamp");

	a_t_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_T] && !deg_s[ST_T] |->
			TS_W'(t_s[ST_T][1]) + TS_W'(t_s[ST_T][2]) == TS_W'(ONE_T))
		else $error("offset parameters not symmetric about one half");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_DVN] && !dv_s[ST_DVN].ovf && !dv_s[ST_DVN].deg |->
			dv_s[ST_DVN].rem < DREM_W'(dv_s[ST_DVN].sum))
		else $error("divider remainder not below divisor");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_LAST] && res_v_q && !result_ready |-> !item_ready)
		else $error("input taken while the pipeline is blocked");
`endif

endmodule

@@ bench/tb_bezier_arrow_point_finder_unit.sv @@
// Self-checking bench for bezier_arrow_point_finder_unit: random and directed
// cubic curves in, three arrow points out, checked against an in-bench model.
// Depends on bapf_pkg and the unit under test.
module tb_bezier_arrow_point_finder_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import bapf_pkg::*;

	// Scoreboard: keeps its own copy of the two registers and the queue of
	// arrow points still owed by the unit.
	class arrow_point_board;
		logic [RES_W-1:0]   res;
		logic [ARROW_W-1:0] arrow;
		out_item_t          owed[$];
		int                 errors;

		function new();
			res    = 24'd65536;
			arrow  = 8'd4;
			errors = 0;
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d want %0d", what, got, want);
			errors++;
		endtask

		// floor(sqrt(x^2 + y^2)), one root bit at a time
		function longint unsigned speed(longint x, longint y);
			longint unsigned n, r, c;
			n = longint'(x * x) + longint'(y * y);
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (c * c <= n)
					r = c;
			end
			return r;
		endfunction

		function longint blend(longint a, longint b, longint t);
			return a + (((b - a) * t + 32768) >>> 16);
		endfunction

		// de Casteljau in three levels, each kept in whole Q15.8 steps
		function coord_t point_at(longint p0, longint p1, longint p2, longint p3,
			longint t);
			longint a, b, c, d, e;
			a = blend(p0, p1, t);
			b = blend(p1, p2, t);
			c = blend(p2, p3, t);
			d = blend(a, b, t);
			e = blend(b, c, t);
			return coord_t'(blend(d, e, t));
		endfunction

		function void note(in_item_t c);
			longint px[4], py[4], vx[4], vy[4];
			longint unsigned len, num, dt;
			longint tm, tp;
			out_item_t o;
			px = '{c.start_x, c.ctrl1_x, c.ctrl2_x, c.end_x};
			py = '{c.start_y, c.ctrl1_y, c.ctrl2_y, c.end_y};
			vx[0] = 9 * (px[1] - px[0]);
			vy[0] = 9 * (py[1] - py[0]);
			vx[1] = 4 * (px[1] - px[0]) + 4 * (px[2] - px[1]) + (px[3] - px[2]);
			vy[1] = 4 * (py[1] - py[0]) + 4 * (py[2] - py[1]) + (py[3] - py[2]);
			vx[2] = (px[1] - px[0]) + 4 * (px[2] - px[1]) + 4 * (px[3] - px[2]);
			vy[2] = (py[1] - py[0]) + 4 * (py[2] - py[1]) + 4 * (py[3] - py[2]);
			vx[3] = 9 * (px[3] - px[2]);
			vy[3] = 9 * (py[3] - py[2]);
			len = speed(vx[0], vy[0]) + 3 * speed(vx[1], vy[1])
				+ 3 * speed(vx[2], vy[2]) + speed(vx[3], vy[3]);
			o = '0;
			if (len == 0) begin
				o.mid_x = c.start_x; o.mid_y = c.start_y;
				o.toward_start_x = c.start_x; o.toward_start_y = c.start_y;
				o.toward_end_x = c.start_x; o.toward_end_y = c.start_y;
				o.degenerate = 1'b1;
			end else begin
				num = (longint'(arrow) * longint'(res) * 24) << 8;
				dt  = num / len;
				if (dt > 32768) begin
					tm = 0; tp = 65536; o.param_clamped = 1'b1;
				end else begin
					tm = 32768 - longint'(dt); tp = 32768 + longint'(dt);
				end
				o.mid_x = point_at(px[0], px[1], px[2], px[3], 32768);
				o.mid_y = point_at(py[0], py[1], py[2], py[3], 32768);
				o.toward_start_x = point_at(px[0], px[1], px[2], px[3], tm);
				o.toward_start_y = point_at(py[0], py[1], py[2], py[3], tm);
				o.toward_end_x = point_at(px[0], px[1], px[2], px[3], tp);
				o.toward_end_y = point_at(py[0], py[1], py[2], py[3], tp);
			end
			owed.push_back(o);
		endfunction

		task check(out_item_t got);
			out_item_t w;
			if (owed.size() == 0) begin
				report("result with nothing owed", 1, 0);
				return;
			end
			w = owed.pop_front();
			if (got.mid_x !== w.mid_x) report("mid_x", got.mid_x, w.mid_x);
			if (got.mid_y !== w.mid_y) report("mid_y", got.mid_y, w.mid_y);
			if (got.toward_start_x !== w.toward_start_x)
				report("toward_start_x", got.toward_start_x, w.toward_start_x);
			if (got.toward_start_y !== w.toward_start_y)
				report("toward_start_y", got.toward_start_y, w.toward_start_y);
			if (got.toward_end_x !== w.toward_end_x)
				report("toward_end_x", got.toward_end_x, w.toward_end_x);
			if (got.toward_end_y !== w.toward_end_y)
				report("toward_end_y", got.toward_end_y, w.toward_end_y);
			if (got.param_clamped !== w.param_clamped)
				report("param_clamped", got.param_clamped, w.param_clamped);
			if (got.degenerate !== w.degenerate)
				report("degenerate", got.degenerate, w.degenerate);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_ready;
	in_item_t              item;
	logic                  result_valid;
	logic                  result_ready;
	out_item_t             result;

	arrow_point_board board;
	bit send_gaps;   // sender idles in bursts
	bit recv_stalls; // receiver stalls in bursts
	bit hold_out;    // request one long receiver hold-off

	bezier_arrow_point_finder_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// Generous ceiling: about 500 curves, each worst case a full stall and gap
	// plus pipeline depth, and the long hold-off, taken many times over.
	initial begin
		#2ms;
		$display("tb_bezier_arrow_point_finder_unit: errors");
		$finish;
	end

	// Check every result transfer against the oldest owed entry.
	always @(posedge clk)
		if (arst_n && result_valid && result_ready)
			board.check(result);

	// Receiver: random stall bursts, or one long hold-off on request.
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				result_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_out = 0;
				result_ready <= 1'b1;
			end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Offer one curve and hold it until the transfer; unless a random sender gap
	// is taken, valid stays high so the next offer can follow without a gap.
	task offer_curve(in_item_t c);
		item       <= c;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		board.note(c);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every owed result has come, then let the
	// pipeline settle.
	task drain;
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.owed.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_SAMPLE_RES)
			board.res = val[RES_W-1:0];
		else
			board.arrow = val[ARROW_W-1:0];
		@(posedge clk);
	endtask

	function in_item_t curve_of(longint x0, longint y0, longint x1, longint y1,
		longint x2, longint y2, longint x3, longint y3);
		in_item_t c;
		c = '{coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1),
			coord_t'(x2), coord_t'(y2), coord_t'(x3), coord_t'(y3)};
		return c;
	endfunction

	function coord_t near(coord_t base, int span);
		return coord_t'(longint'(base) + $urandom_range(0, 2 * span) - span);
	endfunction

	// Mostly compact curves where the arrow offset matters, some full-range
	// noise, straight lines and collapsed points.
	function in_item_t random_curve;
		in_item_t c;
		coord_t bx, by;
		int span, kind;
		kind = $urandom_range(0, 9);
		bx = coord_t'($urandom_range(0, 2 ** 22) - 2 ** 21);
		by = coord_t'($urandom_range(0, 2 ** 22) - 2 ** 21);
		span = 1 << $urandom_range(1, 18);
		if (kind < 2) begin
			c = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		end else if (kind == 2) begin
			c = curve_of(bx, by, bx + span, by, bx + 2 * span, by, bx + 3 * span, by);
		end else if (kind == 3) begin
			c = curve_of(bx, by, bx, by, bx, by, bx, by);
		end else begin
			c = curve_of(bx, by, near(bx, span), near(by, span), near(bx, span),
				near(by, span), near(bx, span), near(by, span));
		end
		return c;
	endfunction

	task random_run(int n);
		repeat (n) offer_curve(random_curve());
	endtask

	initial begin
		board      = new();
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = REG_SAMPLE_RES;
		cfg_data   = '0;
		item_valid = 1'b0;
		item       = '0;
		send_gaps  = 1;
		recv_stalls = 1;
		hold_out   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed curves at reset settings: extremes, collapsed points and
		// straight lines.
		offer_curve(curve_of(0, 0, 0, 0, 0, 0, 0, 0));
		offer_curve(curve_of(-8388608, 8388607, -8388608, 8388607, -8388608,
			8388607, -8388608, 8388607));
		offer_curve(curve_of(-8388608, -8388608, 8388607, 8388607, -8388608,
			-8388608, 8388607, 8388607));
		offer_curve(curve_of(8388607, -8388608, -8388608, 8388607, 8388607,
			-8388608, -8388608, 8388607));
		offer_curve(curve_of(-8388608, -8388608, -8388608, -8388608, 8388607,
			8388607, 8388607, 8388607));
		offer_curve(curve_of(0, 0, 1, 0, 2, 0, 3, 0));
		offer_curve(curve_of(5, 5, 5, 5, 5, 5, 5, 6));
		offer_curve(curve_of(100, 200, 300, -400, 500, 600, -700, 800));
		offer_curve(curve_of(0, 0, 256, 0, 512, 0, 768, 0));
		drain();

		// Straight lines with step 256 and resolution 384*256: offset lands on
		// exactly one half, then a hair above it, which floors to one half again.
		write_reg(REG_SAMPLE_RES, 24'd98304);
		write_reg(REG_ARROW_OFFSET, 24'd1);
		offer_curve(curve_of(0, 0, 256, 0, 512, 0, 768, 0));
		offer_curve(curve_of(0, 0, 0, 256, 0, 512, 0, 768));
		drain();
		write_reg(REG_SAMPLE_RES, 24'd98305);
		offer_curve(curve_of(0, 0, 256, 0, 512, 0, 768, 0));
		drain();

		// Largest settings: nearly every curve clamps.
		write_reg(REG_SAMPLE_RES, 24'hFFFFFF);
		write_reg(REG_ARROW_OFFSET, 24'hFFFFFF);
		offer_curve(curve_of(0, 0, 10, 10, 20, -10, 30, 0));
		offer_curve(curve_of(-8388608, -8388608, 8388607, 8388607, -8388608,
			8388607, 8388607, -8388608));
		random_run(40);
		drain();

		// Zero resolution with arrow 0x12: all three points at the midpoint.
		// Upper data bits on the arrow write must be dropped.
		write_reg(REG_SAMPLE_RES, 24'd0);
		write_reg(REG_ARROW_OFFSET, 24'hABCD12);
		offer_curve(curve_of(0, 0, 1000, 5000, -3000, 2000, 4000, 4000));
		drain();
		write_reg(REG_SAMPLE_RES, 24'd1);
		write_reg(REG_ARROW_OFFSET, 24'h000100);
		offer_curve(curve_of(0, 0, 1000, 5000, -3000, 2000, 4000, 4000));
		random_run(40);
		drain();

		// Back to reset values, then fill the pipe against a held receiver.
		write_reg(REG_SAMPLE_RES, 24'd65536);
		write_reg(REG_ARROW_OFFSET, 24'd4);
		send_gaps = 0;
		hold_out  = 1;
		random_run(120);
		send_gaps = 1;
		drain();

		// Random settings, with a full pause partway through each phase.
		repeat (3) begin
			write_reg(REG_SAMPLE_RES, 24'($urandom_range(1, 24'hFFFFFF) >>
				$urandom_range(0, 16)));
			write_reg(REG_ARROW_OFFSET, 24'($urandom));
			random_run(30);
			drain();
			random_run(20);
			drain();
		end

		// Last stretch runs flat out on both sides.
		write_reg(REG_ARROW_OFFSET, 24'd16);
		send_gaps   = 0;
		recv_stalls = 0;
		random_run(60);
		drain();

		if (board.errors == 0)
			$display("tb_bezier_arrow_point_finder_unit: clean");
		else
			$display("tb_bezier_arrow_point_finder_unit: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/bapf_pkg.sv
sv/bezier_arrow_point_finder_unit.sv
bench/tb_bezier_arrow_point_finder_unit.sv
